[hw/rtl/lcd4_pkg.sv]
`default_nettype none

package lcd4_pkg;

  // request kinds
  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;
  localparam logic [1:0] REQ_GOTO = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SETUP  = 3'd0;
  localparam logic [2:0] REG_PULSE  = 3'd1;
  localparam logic [2:0] REG_SETTLE = 3'd2;
  localparam logic [2:0] REG_POWER  = 3'd3;
  localparam logic [2:0] REG_LONG   = 3'd4;
  localparam logic [2:0] REG_FINAL  = 3'd5;

  localparam logic [15:0] RST_SETUP  = 16'd50;
  localparam logic [15:0] RST_PULSE  = 16'd50;
  localparam logic [15:0] RST_SETTLE = 16'd10000;
  localparam logic [15:0] RST_POWER  = 16'd30000;
  localparam logic [15:0] RST_LONG   = 16'd50000;
  localparam logic [15:0] RST_FINAL  = 16'd5000;

  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_MODE = 4'h2;
  localparam logic [7:0] GOTO_BASE   = 8'h80;
  localparam logic [6:0] ROW2_OFFSET = 7'h40;

  localparam logic [1:0] WAKE_LAST = 2'd2;  // three wake nibbles
  localparam logic [2:0] CMD_LAST  = 3'd4;  // five init commands

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POWER,
    ST_WAKE_EN,
    ST_WAKE_OFF,
    ST_LONG,
    ST_MODE,
    ST_SETUP,
    ST_HI_EN,
    ST_HI_OFF,
    ST_LO_EN,
    ST_LO_OFF,
    ST_END
  } lcd4_state_t;

  // controller -> datapath
  typedef struct packed {
    logic        load;     // capture request
    logic        emit;     // write a pin state to the output word
    lcd4_state_t phase;    // which pin state
    logic        init;     // inside an init sequence
    logic [2:0]  cmd_idx;  // init command number
    logic        last;     // final pin state of the request
  } lcd4_cmd_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h08;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h0C;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lcd4_ctrl.sv]
`default_nettype none

module lcd4_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic [1:0]        req_type,
  input  wire logic              slot_free,
  output logic                   idle,
  output lcd4_pkg::lcd4_cmd_t    cmd
);
  import lcd4_pkg::*;

  lcd4_state_t state_r, state_nxt;
  logic [1:0]  wake_cnt_r, wake_cnt_nxt;
  logic [2:0]  cmd_idx_r, cmd_idx_nxt;
  logic        init_r, init_nxt;
  logic        step;

  assign step = (state_r != ST_IDLE) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wake_cnt_r <= '0;
      cmd_idx_r  <= '0;
      init_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wake_cnt_r <= wake_cnt_nxt;
      cmd_idx_r  <= cmd_idx_nxt;
      init_r     <= init_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    wake_cnt_nxt = wake_cnt_r;
    cmd_idx_nxt  = cmd_idx_r;
    init_nxt     = init_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          init_nxt     = (req_type == REQ_INIT);
          wake_cnt_nxt = '0;
          cmd_idx_nxt  = '0;
          state_nxt    = (req_type == REQ_INIT) ? ST_POWER : ST_SETUP;
        end
      end
      ST_POWER:   if (step) state_nxt = ST_WAKE_EN;
      ST_WAKE_EN: if (step) state_nxt = ST_WAKE_OFF;
      ST_WAKE_OFF: begin
        if (step) begin
          if (wake_cnt_r == WAKE_LAST) begin
            state_nxt = ST_LONG;
          end else begin
            wake_cnt_nxt = wake_cnt_r + 2'd1;
            state_nxt    = ST_WAKE_EN;
          end
        end
      end
      ST_LONG:   if (step) state_nxt = ST_MODE;
      ST_MODE:   if (step) state_nxt = ST_SETUP;
      ST_SETUP:  if (step) state_nxt = ST_HI_EN;
      ST_HI_EN:  if (step) state_nxt = ST_HI_OFF;
      ST_HI_OFF: if (step) state_nxt = ST_LO_EN;
      ST_LO_EN:  if (step) state_nxt = ST_LO_OFF;
      ST_LO_OFF: if (step) state_nxt = ST_END;
      ST_END: begin
        if (step) begin
          if (init_r && (cmd_idx_r != CMD_LAST)) begin
            cmd_idx_nxt = cmd_idx_r + 3'd1;
            state_nxt   = ST_SETUP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle        = (state_r == ST_IDLE);
    cmd.load    = in_fire;
    cmd.emit    = step;
    cmd.phase   = state_r;
    cmd.init    = init_r;
    cmd.cmd_idx = cmd_idx_r;
    cmd.last    = 1'b0;
    case (state_r)
      ST_END:  cmd.last = !init_r || (cmd_idx_r == CMD_LAST);
      default: cmd.last = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/lcd4_dp.sv]
`default_nettype none

module lcd4_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lcd4_pkg::lcd4_cmd_t cmd,
  input  wire logic [1:0]          req_type,
  input  wire logic [7:0]          byte_value,
  input  wire logic                line,
  input  wire logic [6:0]          column,
  input  wire logic                cfg_wr_en,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic                out_tready,
  output logic                     slot_free,
  output logic                     out_valid,
  output logic [3:0]               data_nibble,
  output logic                     reg_select,
  output logic                     enable,
  output logic [15:0]              hold_us,
  output logic                     last
);
  import lcd4_pkg::*;

  logic [15:0] setup_r, pulse_r, settle_r, power_r, long_r, final_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        rs_r;
  logic [6:0]  pos;
  logic        valid_r;
  logic [3:0]  nib_r, nib_nxt;
  logic        rs_out_r, rs_out_nxt;
  logic        en_r, en_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic        last_r;
  logic [7:0]  cur_byte;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r  <= RST_SETUP;
      pulse_r  <= RST_PULSE;
      settle_r <= RST_SETTLE;
      power_r  <= RST_POWER;
      long_r   <= RST_LONG;
      final_r  <= RST_FINAL;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SETUP:  setup_r  <= cfg_wdata;
        REG_PULSE:  pulse_r  <= cfg_wdata;
        REG_SETTLE: settle_r <= cfg_wdata;
        REG_POWER:  power_r  <= cfg_wdata;
        REG_LONG:   long_r   <= cfg_wdata;
        REG_FINAL:  final_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request capture; goto folds into a command byte here
  assign pos = column + (line ? ROW2_OFFSET : 7'd0);

  always_comb begin
    case (req_type)
      REQ_GOTO: byte_nxt = GOTO_BASE | {1'b0, pos};
      default:  byte_nxt = byte_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= byte_nxt;
      rs_r   <= (req_type == REQ_DATA);
    end
  end

  assign cur_byte = cmd.init ? init_cmd(cmd.cmd_idx) : byte_r;

  // pin state for the current phase
  always_comb begin
    nib_nxt    = '0;
    rs_out_nxt = 1'b0;
    en_nxt     = 1'b0;
    hold_nxt   = '0;
    case (cmd.phase)
      ST_POWER: hold_nxt = power_r;
      ST_WAKE_EN: begin
        nib_nxt  = NIB_WAKE;
        en_nxt   = 1'b1;
        hold_nxt = pulse_r;
      end
      ST_WAKE_OFF: begin
        nib_nxt  = NIB_WAKE;
        hold_nxt = settle_r;
      end
      ST_LONG: begin
        nib_nxt  = NIB_WAKE;
        hold_nxt = long_r;
      end
      ST_MODE: begin
        nib_nxt  = NIB_MODE;
        en_nxt   = 1'b1;
        hold_nxt = long_r;
      end
      ST_SETUP: begin
        // first init command still shows the mode nibble
        nib_nxt    = (cmd.init && (cmd.cmd_idx == '0)) ? NIB_MODE : 4'h0;
        rs_out_nxt = rs_r;
        hold_nxt   = setup_r;
      end
      ST_HI_EN: begin
        nib_nxt    = cur_byte[7:4];
        rs_out_nxt = rs_r;
        en_nxt     = 1'b1;
        hold_nxt   = pulse_r;
      end
      ST_HI_OFF: begin
        nib_nxt    = cur_byte[7:4];
        rs_out_nxt = rs_r;
        hold_nxt   = settle_r;
      end
      ST_LO_EN: begin
        nib_nxt    = cur_byte[3:0];
        rs_out_nxt = rs_r;
        en_nxt     = 1'b1;
        hold_nxt   = pulse_r;
      end
      ST_LO_OFF: begin
        nib_nxt    = cur_byte[3:0];
        rs_out_nxt = rs_r;
        hold_nxt   = settle_r;
      end
      ST_END: hold_nxt = (cmd.init && cmd.last) ? final_r : 16'd0;
      default: ;
    endcase
  end

  // output word register
  assign slot_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.emit) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      nib_r    <= nib_nxt;
      rs_out_r <= rs_out_nxt;
      en_r     <= en_nxt;
      hold_r   <= hold_nxt;
      last_r   <= cmd.last;
    end
  end

  assign out_valid   = valid_r;
  assign data_nibble = nib_r;
  assign reg_select  = rs_out_r;
  assign enable      = en_r;
  assign hold_us     = hold_r;
  assign last        = last_r;

endmodule

`default_nettype wire

[hw/rtl/lcd_4bit_interface_sequencer.sv]
`default_nettype none

// Channel  Dir  Signals                          Word layout (lsb first)
// in       in   in_tvalid/in_tready              tdata: byte_value[7:0] line[8]
//                 in_tdata/in_tuser                     column[15:9]
//                                                tuser: req_type[1:0]
// out      out  out_tvalid/out_tready            tdata: data_nibble[3:0] enable[4]
//                 out_tdata/out_tuser                   hold_us[20:5], 0 pad
//                 out_tlast = last               tuser: reg_select
// cfg      in   cfg_wr_en/cfg_index/cfg_wdata    16-bit register, index 0..5
//
// One request is taken at a time. It yields 6 pin-state words (command, data,
// goto) or 39 words (init), one per cycle as long as out_tready stays high.
// in_tready is high only while the sequencer is idle; the request after one
// can be taken while the final word still waits in the output register.
// A low out_tready with a word waiting stalls the sequencer on that pin state.
// Reset (synchronous, rst_n low) returns the controller to idle, drops the
// output word and loads the timing registers with their default values.

module lcd_4bit_interface_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // byte_value, line, column
  input  wire logic [1:0]  in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // data_nibble, enable, hold_us
  output logic             out_tuser,  // reg_select
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import lcd4_pkg::*;

  logic       in_fire;
  logic       idle;
  logic       slot_free;
  lcd4_cmd_t  ctrl_cmd;
  logic [3:0] data_nibble;
  logic       enable;
  logic [15:0] hold_us;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;

  lcd4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .req_type  (in_tuser),
    .slot_free (slot_free),
    .idle      (idle),
    .cmd       (ctrl_cmd)
  );

  lcd4_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctrl_cmd),
    .req_type    (in_tuser),
    .byte_value  (in_tdata[7:0]),
    .line        (in_tdata[8]),
    .column      (in_tdata[15:9]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_tready  (out_tready),
    .slot_free   (slot_free),
    .out_valid   (out_tvalid),
    .data_nibble (data_nibble),
    .reg_select  (out_tuser),
    .enable      (enable),
    .hold_us     (hold_us),
    .last        (out_tlast)
  );

  assign out_tdata = {3'b000, hold_us, enable, data_nibble};

`ifndef NO_ASSERTIONS
  // an accepted request keeps the sequencer busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("sequencer not busy after accepting a request");

  // emitting the final pin state returns the sequencer to idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.emit && ctrl_cmd.last |=> in_tready)
    else $error("sequencer not idle after final pin state");

  // a request never ends with EN high
  a_last_en_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[4])
    else $error("final pin state has EN high");
`endif

endmodule

`default_nettype wire
